// ===== rtl/catmull_rom_path_3d_eval_assert.svh =====
// ----------------------------------------------------------------------------
// catmull_rom_path_3d_eval assertion macros
// shared property forms for the path evaluator checks
// ----------------------------------------------------------------------------
`ifndef CATMULL_ROM_PATH_3D_EVAL_ASSERT_SVH
`define CATMULL_ROM_PATH_3D_EVAL_ASSERT_SVH

// same-cycle implication, clocked on clk, held off during reset
`define CR3D_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cr3d same-cycle check failed");

// next-cycle implication
`define CR3D_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cr3d next-cycle check failed");

`endif

// ===== rtl/cr3d_pkg.sv =====
// ----------------------------------------------------------------------------
// cr3d_pkg
// constants, status codes and queue entry type of the path evaluator
// ----------------------------------------------------------------------------
package cr3d_pkg;

    localparam int MAX_POINTS  = 256;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int T_WIDTH     = 24;

    localparam int SEG_W  = T_WIDTH - FRAC_BITS;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int CMP_W  = ((SEG_W > CNT_W) ? SEG_W : CNT_W) + 2;
    localparam int PT_W   = 3 * COORD_WIDTH;

    // horner accumulator: partial sums reach about 24 times a coordinate
    localparam int ACC_W  = COORD_WIDTH + 6;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] STATUS_EVAL   = 2'd0;
    localparam logic [1:0] STATUS_APPEND = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;
    localparam logic [1:0] STATUS_FULL   = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [ADDR_W-1:0]    addr;
        logic [FRAC_BITS-1:0] frac;
        logic [PT_W-1:0]      point;
    } entry_t;

endpackage

// ===== rtl/cr3d_front.sv =====
// ----------------------------------------------------------------------------
// cr3d_front
// accepts items, tracks the point count and classifies each transaction
// ----------------------------------------------------------------------------
module cr3d_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic signed [cr3d_pkg::COORD_WIDTH-1:0] point_x,
    input  logic signed [cr3d_pkg::COORD_WIDTH-1:0] point_y,
    input  logic signed [cr3d_pkg::COORD_WIDTH-1:0] point_z,
    input  logic [cr3d_pkg::T_WIDTH-1:0]    param_t,
    input  logic                            q_full,
    output logic                            q_push,
    output cr3d_pkg::entry_t                q_data
);

    logic [cr3d_pkg::CNT_W-1:0] count_reg;
    logic [cr3d_pkg::CNT_W-1:0] count_next;
    logic [cr3d_pkg::SEG_W-1:0] seg;
    logic                       table_full;
    logic                       seg_ok;

    assign in_ready   = !q_full;
    assign q_push     = in_valid && in_ready;
    assign seg        = param_t[cr3d_pkg::T_WIDTH-1:cr3d_pkg::FRAC_BITS];
    assign table_full = (count_reg == cr3d_pkg::CNT_W'(cr3d_pkg::MAX_POINTS));
    // needs seg + 3 < count
    assign seg_ok     = ((cr3d_pkg::CMP_W'(seg) + cr3d_pkg::CMP_W'(3))
                         < cr3d_pkg::CMP_W'(count_reg));

    always_comb
    begin
        q_data.point = {point_x, point_y, point_z};
        q_data.frac  = param_t[cr3d_pkg::FRAC_BITS-1:0];
        q_data.addr  = cr3d_pkg::ADDR_W'(seg);
        count_next   = count_reg;
        if (!mode)
        begin
            q_data.addr = count_reg[cr3d_pkg::ADDR_W-1:0];
            if (table_full)
            begin
                q_data.kind = cr3d_pkg::STATUS_FULL;
            end
            else
            begin
                q_data.kind = cr3d_pkg::STATUS_APPEND;
                if (q_push)
                begin
                    count_next = count_reg + cr3d_pkg::CNT_W'(1);
                end
            end
        end
        else if (seg_ok)
        begin
            q_data.kind = cr3d_pkg::STATUS_EVAL;
        end
        else
        begin
            q_data.kind = cr3d_pkg::STATUS_RANGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/cr3d_queue.sv =====
// ----------------------------------------------------------------------------
// cr3d_queue
// short fifo of classified transactions between front and back
// ----------------------------------------------------------------------------
module cr3d_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cr3d_pkg::entry_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output cr3d_pkg::entry_t head
);

    cr3d_pkg::entry_t              slot_reg [cr3d_pkg::QDEPTH];
    logic [cr3d_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [cr3d_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [cr3d_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [cr3d_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [cr3d_pkg::QCNT_W-1:0]   fill_reg;
    logic [cr3d_pkg::QCNT_W-1:0]   fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign full      = (fill_reg == cr3d_pkg::QCNT_W'(cr3d_pkg::QDEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == cr3d_pkg::QPTR_W'(cr3d_pkg::QDEPTH - 1))
                        ? '0 : wr_ptr_reg + cr3d_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == cr3d_pkg::QPTR_W'(cr3d_pkg::QDEPTH - 1))
                        ? '0 : rd_ptr_reg + cr3d_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + cr3d_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - cr3d_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/cr3d_back.sv =====
// ----------------------------------------------------------------------------
// cr3d_back
// point memory, four-tap fetch, per-axis horner evaluation and result register
// ----------------------------------------------------------------------------
module cr3d_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    q_valid,
    input  cr3d_pkg::entry_t                        q_entry,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [cr3d_pkg::COORD_WIDTH-1:0] out_x,
    output logic signed [cr3d_pkg::COORD_WIDTH-1:0] out_y,
    output logic signed [cr3d_pkg::COORD_WIDTH-1:0] out_z,
    output logic [1:0]                              status
);

    localparam int CW       = cr3d_pkg::COORD_WIDTH;
    localparam int AW       = cr3d_pkg::ACC_W;
    localparam int FB       = cr3d_pkg::FRAC_BITS;
    localparam int PROD_W   = AW + FB + 1;
    localparam int TAPS     = 4;
    localparam int TAP_W    = $clog2(TAPS);
    localparam int RD_CNT_W = $clog2(TAPS + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_COEF   = 5'b00100,
        S_HORNER = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [RD_CNT_W-1:0]           cnt_reg;
    logic [RD_CNT_W-1:0]           cnt_next;
    logic [1:0]                    step_reg;
    logic [1:0]                    step_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    logic [cr3d_pkg::PT_W-1:0]     mem [cr3d_pkg::MAX_POINTS];
    logic [cr3d_pkg::PT_W-1:0]     mem_q_reg;
    logic [cr3d_pkg::ADDR_W-1:0]   rd_addr;
    logic                          mem_we;

    logic [cr3d_pkg::ADDR_W-1:0]   seg_reg;
    logic [FB-1:0]                 frac_reg;
    logic [cr3d_pkg::PT_W-1:0]     pt_reg [TAPS];
    logic signed [AW-1:0]          coef_a_reg [3];
    logic signed [AW-1:0]          coef_b_reg [3];
    logic signed [AW-1:0]          coef_c_reg [3];
    logic signed [AW-1:0]          acc_reg [3];
    logic signed [AW-1:0]          horner_val [3];
    logic signed [CW-1:0]          sat_val [3];

    logic signed [CW-1:0]          out_x_reg;
    logic signed [CW-1:0]          out_y_reg;
    logic signed [CW-1:0]          out_z_reg;
    logic [1:0]                    status_reg;

    logic                          out_free;
    logic                          load_direct;
    logic                          load_eval;
    logic [TAP_W-1:0]              tap_idx;

    // floor(x * f / 2^FB), exact since the product is kept whole
    function automatic logic signed [AW-1:0] mul_frac(
        input logic signed [AW-1:0] x,
        input logic [FB-1:0]        f
    );
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] shifted;
        begin
            prod    = PROD_W'(x) * PROD_W'($signed({1'b0, f}));
            shifted = prod >>> FB;
            return shifted[AW-1:0];
        end
    endfunction

    function automatic logic signed [AW-1:0] coord_of(
        input logic [cr3d_pkg::PT_W-1:0] pt,
        input int                        axis
    );
        logic signed [CW-1:0] v;
        begin
            v = $signed(pt[(2 - axis) * CW +: CW]);
            return AW'(v);
        end
    endfunction

    assign out_free    = !out_valid_reg || out_ready;
    assign load_direct = (state_reg == S_IDLE) && q_valid
                         && (q_entry.kind != cr3d_pkg::STATUS_EVAL) && out_free;
    assign load_eval   = (state_reg == S_FINISH) && out_free;
    assign q_pop       = (state_reg == S_IDLE) && q_valid
                         && ((q_entry.kind == cr3d_pkg::STATUS_EVAL) || out_free);
    assign mem_we      = load_direct && (q_entry.kind == cr3d_pkg::STATUS_APPEND);
    assign rd_addr     = seg_reg + cr3d_pkg::ADDR_W'(cnt_reg);
    assign tap_idx     = TAP_W'(cnt_reg - RD_CNT_W'(1));

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign status    = status_reg;

    // one horner step per axis: next coefficient plus the scaled accumulator
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            case (step_reg)
                2'd0:    horner_val[ax] = coef_c_reg[ax] + mul_frac(acc_reg[ax], frac_reg);
                2'd1:    horner_val[ax] = coef_b_reg[ax] + mul_frac(acc_reg[ax], frac_reg);
                default: horner_val[ax] = coef_a_reg[ax] + mul_frac(acc_reg[ax], frac_reg);
            endcase
        end
    end

    // halve with floor, then clamp to the coordinate range
    always_comb
    begin
        for (int ax = 0; ax < 3; ax++)
        begin
            logic signed [AW-1:0] h;
            h = acc_reg[ax] >>> 1;
            if (!h[AW-1] && (|h[AW-2:CW-1]))
            begin
                sat_val[ax] = {1'b0, {(CW - 1){1'b1}}};
            end
            else if (h[AW-1] && !(&h[AW-2:CW-1]))
            begin
                sat_val[ax] = {1'b1, {(CW - 1){1'b0}}};
            end
            else
            begin
                sat_val[ax] = h[CW-1:0];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_direct || load_eval)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop && (q_entry.kind == cr3d_pkg::STATUS_EVAL))
                begin
                    state_next = S_READ;
                    cnt_next   = '0;
                end
            end
            S_READ:
            begin
                cnt_next = cnt_reg + RD_CNT_W'(1);
                if (cnt_reg == RD_CNT_W'(TAPS))
                begin
                    state_next = S_COEF;
                end
            end
            S_COEF:
            begin
                state_next = S_HORNER;
                step_next  = '0;
            end
            S_HORNER:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // point memory, single write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_entry.addr] <= q_entry.point;
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && q_pop)
        begin
            seg_reg  <= q_entry.addr;
            frac_reg <= q_entry.frac;
        end
        if ((state_reg == S_READ) && (cnt_reg != '0))
        begin
            pt_reg[tap_idx] <= mem_q_reg;
        end
        if (state_reg == S_COEF)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                logic signed [AW-1:0] p0;
                logic signed [AW-1:0] p1;
                logic signed [AW-1:0] p2;
                logic signed [AW-1:0] p3;
                p0 = coord_of(pt_reg[0], ax);
                p1 = coord_of(pt_reg[1], ax);
                p2 = coord_of(pt_reg[2], ax);
                p3 = coord_of(pt_reg[3], ax);
                coef_a_reg[ax] <= p1 <<< 1;
                coef_b_reg[ax] <= p2 - p0;
                coef_c_reg[ax] <= (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
                // horner starts from the cubic coefficient
                acc_reg[ax]    <= ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3 - p0;
            end
        end
        if (state_reg == S_HORNER)
        begin
            for (int ax = 0; ax < 3; ax++)
            begin
                acc_reg[ax] <= horner_val[ax];
            end
        end
        if (load_direct)
        begin
            out_x_reg  <= '0;
            out_y_reg  <= '0;
            out_z_reg  <= '0;
            status_reg <= q_entry.kind;
        end
        else if (load_eval)
        begin
            out_x_reg  <= sat_val[0];
            out_y_reg  <= sat_val[1];
            out_z_reg  <= sat_val[2];
            status_reg <= cr3d_pkg::STATUS_EVAL;
        end
    end

`include "catmull_rom_path_3d_eval_assert.svh"

    `CR3D_ASSERT_IMPL(a_zero_unless_eval, out_valid_reg && (status_reg != cr3d_pkg::STATUS_EVAL), (out_x_reg == '0) && (out_y_reg == '0) && (out_z_reg == '0))
    `CR3D_ASSERT_NEXT(a_eval_starts_fetch, (state_reg == S_IDLE) && q_pop && (q_entry.kind == cr3d_pkg::STATUS_EVAL), state_reg == S_READ)
    `CR3D_ASSERT_NEXT(a_fetch_ends, (state_reg == S_READ) && (cnt_reg == RD_CNT_W'(TAPS)), state_reg == S_COEF)
    `CR3D_ASSERT_IMPL(a_pop_only_idle, q_pop, state_reg == S_IDLE)

endmodule

// ===== rtl/catmull_rom_path_3d_eval.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_path_3d_eval
// uniform catmull-rom path over a table of 3d control points
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_ready    mode, point_x, point_y, point_z, param_t
//  output    out_valid / out_ready  out_x, out_y, out_z, status
//
//  append, full and out-of-range: one per cycle while the back is idle and the output is free
//  evaluate: one at a time in the back; it leaves the queue, reads four taps from the point
//  memory through its registered read port, forms the coefficients, takes three horner steps
//  and loads the result register
//  reset clears the point count and the queue; the point memory is not cleared
//  a waiting result stalls the back; input stalls once the two-entry queue is full
// ----------------------------------------------------------------------------
module catmull_rom_path_3d_eval (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    mode,
    input  logic signed [cr3d_pkg::COORD_WIDTH-1:0] point_x,
    input  logic signed [cr3d_pkg::COORD_WIDTH-1:0] point_y,
    input  logic signed [cr3d_pkg::COORD_WIDTH-1:0] point_z,
    input  logic [cr3d_pkg::T_WIDTH-1:0]            param_t,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [cr3d_pkg::COORD_WIDTH-1:0] out_x,
    output logic signed [cr3d_pkg::COORD_WIDTH-1:0] out_y,
    output logic signed [cr3d_pkg::COORD_WIDTH-1:0] out_z,
    output logic [1:0]                              status
);

    logic             q_full;
    logic             q_push;
    cr3d_pkg::entry_t q_data;
    logic             q_pop;
    logic             q_valid;
    cr3d_pkg::entry_t q_head;

    cr3d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .param_t  (param_t),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    cr3d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    cr3d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .status    (status)
    );

endmodule

// ===== sim/catmull_rom_path_3d_eval_test.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_path_3d_eval_test
// self-checking bench for the catmull-rom path evaluator: appends control
// points and evaluates the spline, predicting each result in exact fixed
// point and comparing it field by field as it leaves the block
// ----------------------------------------------------------------------------
module catmull_rom_path_3d_eval_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_WIDTH = cr3d_pkg::COORD_WIDTH;
    localparam int MAX_POINTS  = cr3d_pkg::MAX_POINTS;
    localparam int FRAC_BITS   = cr3d_pkg::FRAC_BITS;
    localparam int T_WIDTH     = cr3d_pkg::T_WIDTH;
    localparam int SEG_W       = cr3d_pkg::SEG_W;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 2000;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 32;
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int REPORT_LIMIT = 10;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_EVAL   = 1'b1;

    localparam logic signed [COORD_WIDTH-1:0] COORD_HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam longint SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam logic [FRAC_BITS-1:0] FRAC_TOP = {FRAC_BITS{1'b1}};

    typedef struct {
        logic                          mode;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
        logic [T_WIDTH-1:0]            t;
    } path_item_t;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic [1:0]                    status;
    } path_result_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic                          mode      = MODE_APPEND;
    logic signed [COORD_WIDTH-1:0] point_x   = '0;
    logic signed [COORD_WIDTH-1:0] point_y   = '0;
    logic signed [COORD_WIDTH-1:0] point_z   = '0;
    logic [T_WIDTH-1:0]            param_t   = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic [1:0]                    status;

    // stimulus and prediction state
    path_item_t   pending_items[$];
    path_result_t expected_results[$];
    logic signed [COORD_WIDTH-1:0] ctrl_x [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] ctrl_y [MAX_POINTS];
    logic signed [COORD_WIDTH-1:0] ctrl_z [MAX_POINTS];
    int ctrl_count  = 0;
    int queued_pts  = 0;
    int total_items = 0;
    int n_accepted  = 0;
    int mismatches  = 0;
    int stall_cycles = 0;

    // sender and receiver pacing
    path_item_t next_item;
    int burst_left  = 1;
    int gap_left    = 0;
    int rx_pattern  = 0;
    int rx_phase    = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    bit rx_ready;

    catmull_rom_path_3d_eval DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .param_t   (param_t),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .status    (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // one axis of the spline by horner's rule, floors throughout, then saturate
    function automatic logic signed [COORD_WIDTH-1:0] catmull_axis(
        input longint p0, input longint p1, input longint p2, input longint p3,
        input longint f);
        longint a, b, c, d, v2, v1, v0, h;
        a  = 2 * p1;
        b  = p2 - p0;
        c  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        d  = -p0 + 3 * p1 - 3 * p2 + p3;
        v2 = c + ((d * f) >>> FRAC_BITS);
        v1 = b + ((v2 * f) >>> FRAC_BITS);
        v0 = a + ((v1 * f) >>> FRAC_BITS);
        h  = v0 >>> 1;
        if (h > SAT_HI)
            h = SAT_HI;
        if (h < SAT_LO)
            h = SAT_LO;
        return h[COORD_WIDTH-1:0];
    endfunction

    // updates the point table for one accepted transaction and queues its result
    task automatic apply_path_item(input path_item_t it);
        path_result_t r;
        int seg;
        longint f;
        r.x = '0;
        r.y = '0;
        r.z = '0;
        if (it.mode == MODE_APPEND)
        begin
            if (ctrl_count >= MAX_POINTS)
            begin
                r.status = cr3d_pkg::STATUS_FULL;
            end
            else
            begin
                ctrl_x[ctrl_count] = it.px;
                ctrl_y[ctrl_count] = it.py;
                ctrl_z[ctrl_count] = it.pz;
                ctrl_count++;
                r.status = cr3d_pkg::STATUS_APPEND;
            end
        end
        else
        begin
            seg = int'(it.t >> FRAC_BITS);
            f   = longint'(it.t[FRAC_BITS-1:0]);
            if (seg + 3 >= ctrl_count)
            begin
                r.status = cr3d_pkg::STATUS_RANGE;
            end
            else
            begin
                r.x = catmull_axis(ctrl_x[seg], ctrl_x[seg+1], ctrl_x[seg+2],
                                   ctrl_x[seg+3], f);
                r.y = catmull_axis(ctrl_y[seg], ctrl_y[seg+1], ctrl_y[seg+2],
                                   ctrl_y[seg+3], f);
                r.z = catmull_axis(ctrl_z[seg], ctrl_z[seg+1], ctrl_z[seg+2],
                                   ctrl_z[seg+3], f);
                r.status = cr3d_pkg::STATUS_EVAL;
            end
        end
        expected_results = {expected_results, r};
    endtask

    task automatic queue_append(input logic signed [COORD_WIDTH-1:0] x,
                                input logic signed [COORD_WIDTH-1:0] y,
                                input logic signed [COORD_WIDTH-1:0] z);
        path_item_t it;
        it.mode = MODE_APPEND;
        it.px   = x;
        it.py   = y;
        it.pz   = z;
        it.t    = T_WIDTH'($urandom);
        pending_items = {pending_items, it};
        if (queued_pts < MAX_POINTS)
            queued_pts++;
    endtask

    task automatic queue_eval(input int seg, input logic [FRAC_BITS-1:0] frac);
        path_item_t it;
        it.mode = MODE_EVAL;
        it.px   = $urandom;
        it.py   = $urandom;
        it.pz   = $urandom;
        it.t    = {seg[SEG_W-1:0], frac};
        pending_items = {pending_items, it};
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom;
            3:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            4:       return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            default:
                case ($urandom_range(0, 3))
                    0:       return COORD_HI;
                    1:       return COORD_LO;
                    2:       return '0;
                    default: return -1;
                endcase
        endcase
    endfunction

    function automatic logic [FRAC_BITS-1:0] rand_frac();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FRAC_TOP;
            default: return FRAC_BITS'($urandom);
        endcase
    endfunction

    // driver: paced in bursts, predicts each transaction as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                next_item.mode = mode;
                next_item.px   = point_x;
                next_item.py   = point_y;
                next_item.pz   = point_z;
                next_item.t    = param_t;
                apply_path_item(next_item);
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0 || pending_items.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    mode     <= next_item.mode;
                    point_x  <= next_item.px;
                    point_y  <= next_item.py;
                    point_z  <= next_item.pz;
                    param_t  <= next_item.t;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // receiver: changes stall pattern every so often, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (rx_phase == 0)
            begin
                rx_phase   = $urandom_range(50, 300);
                rx_pattern = $urandom_range(0, 3);
            end
            rx_phase--;
            if (!hold_done && n_accepted >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rx_ready = 1'b0;
            end
            else
            begin
                case (rx_pattern)
                    0:       rx_ready = 1'b1;
                    1:       rx_ready = ($urandom_range(0, 9) < 7);
                    2:       rx_ready = (rx_phase % 3 == 0);
                    default: rx_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ready <= rx_ready;
        end
    end

    // monitor: compares each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result: x=%0d y=%0d z=%0d status=%0d",
                                 out_x, out_y, out_z, status);
                end
                else if (out_x !== expected_results[0].x || out_y !== expected_results[0].y ||
                         out_z !== expected_results[0].z ||
                         status !== expected_results[0].status)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"mismatch: exp x=%0d y=%0d z=%0d status=%0d, ",
                                  "got x=%0d y=%0d z=%0d status=%0d"},
                                 expected_results[0].x, expected_results[0].y,
                                 expected_results[0].z, expected_results[0].status,
                                 out_x, out_y, out_z, status);
                    void'(expected_results.pop_front());
                end
                else
                begin
                    void'(expected_results.pop_front());
                end
            end
        end
    end

    // watchdog: nothing accepted on either side for too long
    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("catmull_rom_path_3d_eval regression: fail");
        $finish;
    end

    initial
    begin
        int pick;

        // directed: empty table, short table, extremes, saturation, segment edges
        queue_eval(0, '0);
        queue_append('0, '0, '0);
        queue_append(COORD_HI, COORD_LO, COORD_HI);
        queue_append(COORD_LO, COORD_HI, COORD_LO);
        queue_eval(0, '0);
        queue_eval(0, FRAC_TOP);
        queue_append(COORD_HI, COORD_LO, 1);
        queue_eval(0, '0);
        queue_eval(0, FRAC_TOP);
        queue_eval(0, 16'h8000);
        queue_eval(0, 16'h0001);
        queue_eval(1, '0);
        queue_eval(2 ** SEG_W - 1, FRAC_TOP);
        queue_append(-1, 1, 32'sh1234_5678);
        queue_append(COORD_LO, COORD_LO, COORD_HI);
        queue_eval(1, 16'h4000);
        queue_eval(2, 16'hc000);
        queue_eval(2, FRAC_TOP);
        queue_eval(3, '0);
        queue_append(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000);
        queue_eval(3, 16'h5555);

        // random: well-formed evaluations over the current table, appends until
        // it fills, then attempts on the full table, with out-of-range noise
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < ((queued_pts < MAX_POINTS) ? 30 : 4))
                queue_append(rand_coord(), rand_coord(), rand_coord());
            else if (pick < 88 && queued_pts >= 4)
                queue_eval($urandom_range(0, queued_pts - 4), rand_frac());
            else
                queue_eval($urandom_range(0, 2 ** SEG_W - 1), rand_frac());
        end
        total_items = pending_items.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("catmull_rom_path_3d_eval regression: pass");
        else
            $display("catmull_rom_path_3d_eval regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cr3d_pkg.sv
rtl/cr3d_front.sv
rtl/cr3d_queue.sv
rtl/cr3d_back.sv
rtl/catmull_rom_path_3d_eval.sv
sim/catmull_rom_path_3d_eval_test.sv
